### sv/uitf_pkg.sv
// uitf_pkg: shared constants, state encoding and controller/datapath bundles
// for the uart idle timeout framer; no dependencies
package uitf_pkg;

  // frame buffer size and derived widths
  localparam int MAX_FRAME = 64;
  localparam int CNT_W     = $clog2(MAX_FRAME + 1);
  localparam int ADDR_W    = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;

  // fixed field widths
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 7;
  localparam int IDLE_W    = 16;
  localparam int APB_DW    = 32;
  localparam int PADDR_W   = 3;

  // register map (word index) and defaults
  localparam logic       REG_IDLE_TIMEOUT = 1'b0;
  localparam logic [IDLE_W-1:0] IDLE_TIMEOUT_RST = IDLE_W'(10);
  localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

  // input op codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEND
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic byte_en;  // byte beat accepted
    logic tick_en;  // tick beat accepted
    logic read_en;  // read buffer entry at the readout index
    logic step;     // current beat taken, advance readout index
    logic close;    // final beat taken, clear the frame
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic close_pending;  // a tick now would close the frame
    logic last;           // readout index is on the final byte
  } dp_status_t;

endpackage

### sv/uitf_if.sv
// uitf_in_if / uitf_out_if: valid/ready channel bundles for input items and
// frame beats; depends on uitf_pkg
interface uitf_in_if;
  import uitf_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, op, rx_byte, input ready);
  modport sink   (input valid, op, rx_byte, output ready);
endinterface

interface uitf_out_if;
  import uitf_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic [LEN_W-1:0]  frame_length;
  logic              frame_last;

  modport source (output valid, frame_byte, frame_length, frame_last, input ready);
  modport sink   (input valid, frame_byte, frame_length, frame_last, output ready);
endinterface

### sv/uitf_ram.sv
// uitf_ram: generic single write port, single read port ram with registered
// read data; no dependencies
module uitf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/uitf_regs.sv
// uitf_regs: apb-style configuration register for the idle timeout
// depends on uitf_pkg
module uitf_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [uitf_pkg::PADDR_W-1:0]   paddr,
  input  logic [uitf_pkg::APB_DW-1:0]    pwdata,
  output logic [uitf_pkg::APB_DW-1:0]    prdata,
  output logic                           pready,
  output logic [uitf_pkg::IDLE_W-1:0]    idle_timeout
);
  import uitf_pkg::*;

  logic wr_en;
  logic sel_timeout;

  assign pready      = 1'b1;
  assign sel_timeout = (paddr[2] == REG_IDLE_TIMEOUT);
  assign wr_en       = psel & penable & pwrite;

  // timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout <= IDLE_TIMEOUT_RST;
    end else if (wr_en && sel_timeout) begin
      idle_timeout <= pwdata[IDLE_W-1:0];
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    if (sel_timeout) begin
      prdata = APB_DW'(idle_timeout);
    end
  end

endmodule

### sv/uitf_dp.sv
// uitf_dp: frame datapath: byte count, idle counter, lock flag, readout index
// and the frame buffer ram; depends on uitf_pkg and uitf_ram
module uitf_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  uitf_pkg::ctrl_cmd_t           cmd,
  output uitf_pkg::dp_status_t          status,
  input  logic [uitf_pkg::IDLE_W-1:0]   idle_timeout,
  input  logic [uitf_pkg::BYTE_W-1:0]   rx_byte,
  output logic [uitf_pkg::BYTE_W-1:0]   frame_byte,
  output logic [uitf_pkg::LEN_W-1:0]    frame_length,
  output logic                          frame_last
);
  import uitf_pkg::*;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [IDLE_W-1:0] idle;
  logic [IDLE_W-1:0] idle_next;
  logic [IDLE_W-1:0] idle_inc;
  logic              locked;
  logic              locked_next;
  logic [ADDR_W-1:0] rd_idx;
  logic [ADDR_W-1:0] rd_idx_next;
  logic              pending_now;
  logic              full;
  logic              store_en;

  // frame state checks
  assign idle_inc    = (idle == IDLE_MAX) ? idle : idle + IDLE_W'(1);
  assign pending_now = (count != '0) && (idle > idle_timeout);
  assign full        = (count >= CNT_W'(MAX_FRAME));
  assign store_en    = cmd.byte_en && !locked && !pending_now && !full;

  assign status.close_pending = (count != '0) && (idle_inc > idle_timeout);
  assign status.last          = ((CNT_W'(rd_idx) + CNT_W'(1)) == count);

  // next state of count, idle, lock and readout index
  always_comb begin
    count_next  = count;
    idle_next   = idle;
    locked_next = locked;
    rd_idx_next = rd_idx;
    if (cmd.byte_en && !locked) begin
      if (pending_now || full) begin
        locked_next = 1'b1;
      end else begin
        count_next = count + CNT_W'(1);
        idle_next  = '0;
      end
    end
    if (cmd.tick_en) begin
      idle_next = idle_inc;
    end
    if (cmd.step) begin
      rd_idx_next = rd_idx + ADDR_W'(1);
    end
    if (cmd.close) begin
      count_next  = '0;
      locked_next = 1'b0;
      rd_idx_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      idle   <= '0;
      locked <= 1'b0;
      rd_idx <= '0;
    end else begin
      count  <= count_next;
      idle   <= idle_next;
      locked <= locked_next;
      rd_idx <= rd_idx_next;
    end
  end

  // last marker follows the entry being read
  always_ff @(posedge clk) begin
    if (cmd.read_en) begin
      frame_last <= status.last;
    end
  end

  // frame buffer
  uitf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_FRAME)
  ) u_buf (
    .clk   (clk),
    .we    (store_en),
    .waddr (count[ADDR_W-1:0]),
    .wdata (rx_byte),
    .re    (cmd.read_en),
    .raddr (rd_idx),
    .rdata (frame_byte)
  );

  assign frame_length = LEN_W'(count);

  // count never passes the buffer size
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_FRAME))
    else $error("byte count above buffer size");

  // a closed frame leaves the buffer empty and unlocked
  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.close |=> (count == '0) && !locked)
    else $error("frame not cleared after close");

  // a stored byte restarts the idle counter
  a_store_idle: assert property (@(posedge clk) disable iff (rst)
    store_en |=> (idle == '0) && (count == $past(count) + CNT_W'(1)))
    else $error("byte store did not update count and idle");

endmodule

### sv/uitf_ctrl.sv
// uitf_ctrl: handshake and readout sequencer for the framer
// depends on uitf_pkg
module uitf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_op,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  uitf_pkg::dp_status_t  status,
  output uitf_pkg::ctrl_cmd_t   cmd
);
  import uitf_pkg::*;

  state_t state;
  state_t state_next;
  logic   in_take;
  logic   out_take;

  assign in_take  = in_valid && in_ready;
  assign out_take = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_take && (in_op == OP_TICK) && status.close_pending) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (out_take) begin
          state_next = status.last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.byte_en = in_valid && (in_op == OP_BYTE);
        cmd.tick_en = in_valid && (in_op == OP_TICK);
      end
      ST_READ: begin
        cmd.read_en = 1'b1;
      end
      ST_SEND: begin
        out_valid = 1'b1;
        cmd.step  = out_ready && !status.last;
        cmd.close = out_ready && status.last;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // input and output sides are never open together
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output open together");

  // every buffer read is followed by a beat offer
  a_read_send: assert property (@(posedge clk) disable iff (rst)
    cmd.read_en |=> out_valid)
    else $error("buffer read not followed by a beat");

  // readout begins only from a tick that closes a frame
  a_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) && (state_next == ST_READ) |-> cmd.tick_en && status.close_pending)
    else $error("readout started without a closing tick");

endmodule

### sv/uitf_top.sv
// uart_idle_timeout_framer_top: top level of the uart idle timeout framer
// depends on uitf_pkg, uitf_if, uitf_regs, uitf_ctrl, uitf_dp, uitf_ram
//
// The framer takes byte beats and tick beats on in_ch and emits completed
// frames on out_ch, one beat per byte with the frame length on every beat and
// frame_last on the final one. A byte beat or a tick beat that closes no
// frame is taken in the same cycle it is offered, and the next beat can follow
// at once. A tick that closes a frame of N bytes starts a readout of the
// 64 x 8 frame buffer ram, one entry at a time: each byte is first read from
// the ram and then offered as a beat, and in_ch is held not ready until the
// last beat is taken.
// idle_timeout sits at byte address 0 of the apb-style port, reset value 10.
module uart_idle_timeout_framer_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [uitf_pkg::PADDR_W-1:0]  paddr,
  input  logic [uitf_pkg::APB_DW-1:0]   pwdata,
  output logic [uitf_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  uitf_in_if.sink                       in_ch,
  uitf_out_if.source                    out_ch
);
  import uitf_pkg::*;

  logic [IDLE_W-1:0] idle_timeout;
  ctrl_cmd_t         cmd;
  dp_status_t        status;

  // configuration register
  uitf_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .idle_timeout (idle_timeout)
  );

  // sequencer
  uitf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // frame datapath
  uitf_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .idle_timeout (idle_timeout),
    .rx_byte      (in_ch.rx_byte),
    .frame_byte   (out_ch.frame_byte),
    .frame_length (out_ch.frame_length),
    .frame_last   (out_ch.frame_last)
  );

endmodule
